// File: rtl/vnf_pkg.sv
// Shared constants for the value noise fbm generator.
// Hash multipliers, octave scales, seed offsets and weights. No dependencies.
package vnf_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NUM_OCT   = 3;
  localparam int unsigned NUM_CRN   = 4;
  localparam int unsigned NUM_STG   = 11;

  localparam logic [31:0] HASH_MX = 32'd374761393;
  localparam logic [31:0] HASH_MY = 32'd668265263;
  localparam logic [31:0] HASH_MS = 32'd974634;
  localparam logic [31:0] HASH_MF = 32'd1274126177;

  localparam logic [18:0] OCT_SCALE [NUM_OCT] = '{19'd65536, 19'd137626, 19'd281805};
  localparam logic [31:0] OCT_SEED  [NUM_OCT] = '{32'd0, 32'd11, 32'd23};
  localparam logic [15:0] OCT_WGT   [NUM_OCT] = '{16'd36045, 16'd19661, 16'd9830};

  localparam logic [2:0] REG_FBM_ADDR = 3'd0;

endpackage

// File: rtl/value_noise_fbm_generator.sv
// Value noise fbm generator: top level and full datapath.
// Depends on vnf_pkg.
//
// Usage:
//   Input words (coord_x_i, coord_y_i, seed_i) enter on in_valid_i/in_ready_o,
//   result words (noise_value_o) leave on out_valid_o/out_ready_i. One result
//   per input word, in order.
//   Throughput is one word per cycle while the receiver does not stall:
//   three octave lanes, each with its own multipliers, run side by side in
//   an 11-stage pipeline.
//   fbm_enable sits at APB byte address 0 (reset 1) and is latched per word
//   when the word is accepted.
//   Reset clears all stage valid bits and sets fbm_enable; the pipeline is
//   empty and in_ready_o is high.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready_o drops; nothing is lost or repeated, and it resumes at full
//   rate once out_ready_i returns.
module value_noise_fbm_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] seed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        noise_value_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import vnf_pkg::*;

  logic               fbm_en_q;
  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG-1:0] fbm_q;
  logic               en;

  logic signed [31:0] cx1_q, cy1_q;
  logic [31:0]        sd1_q;
  logic signed [51:0] px2_q [NUM_OCT];
  logic signed [51:0] py2_q [NUM_OCT];
  logic [31:0]        sd2_q [NUM_OCT];
  logic [31:0]        ix3_d [NUM_OCT], ix3_q [NUM_OCT];
  logic [31:0]        iy3_d [NUM_OCT], iy3_q [NUM_OCT];
  logic [15:0]        fx3_d [NUM_OCT], fx3_q [NUM_OCT];
  logic [15:0]        fy3_d [NUM_OCT], fy3_q [NUM_OCT];
  logic [31:0]        sd3_q [NUM_OCT];
  logic [31:0]        ha4_q [NUM_OCT], hb4_q [NUM_OCT], hs4_q [NUM_OCT];
  logic [31:0]        tx4_q [NUM_OCT], ty4_q [NUM_OCT];
  logic [15:0]        fx4_q [NUM_OCT], fy4_q [NUM_OCT];
  logic [31:0]        h5_d  [NUM_OCT][NUM_CRN], h5_q [NUM_OCT][NUM_CRN];
  logic [15:0]        wx5_d [NUM_OCT], wx5_q [NUM_OCT];
  logic [15:0]        wy5_d [NUM_OCT], wy5_q [NUM_OCT];
  logic [31:0]        m6_q  [NUM_OCT][NUM_CRN];
  logic [15:0]        wx6_q [NUM_OCT], wy6_q [NUM_OCT];
  logic [32:0]        p7_d  [NUM_OCT][NUM_CRN], p7_q [NUM_OCT][NUM_CRN];
  logic [15:0]        wy7_q [NUM_OCT];
  logic [49:0]        q8_d  [NUM_OCT][NUM_CRN], q8_q [NUM_OCT][NUM_CRN];
  logic [31:0]        oct9_d [NUM_OCT], oct9_q [NUM_OCT];
  logic [47:0]        r10_q [NUM_OCT];
  logic [15:0]        hi10_q;
  logic [15:0]        noise_d, noise_q;

  assign en          = !vld_q[NUM_STG-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NUM_STG-1];
  assign noise_value_o = noise_q;

  // config port
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr == REG_FBM_ADDR) begin
      prdata = {31'd0, fbm_en_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbm_en_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr == REG_FBM_ADDR)) begin
      fbm_en_q <= pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      fbm_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NUM_STG-2:0], in_valid_i};
      fbm_q <= {fbm_q[NUM_STG-2:0], fbm_en_q};
    end
  end

  always_comb begin
    logic signed [39:0] scx, scy;
    logic [17:0]        kx, ky;
    logic [31:0]        hs;
    logic [31:0]        mv;
    logic [15:0]        crn;
    logic [16:0]        wxt, wyt;
    logic [50:0]        acc;
    for (int o = 0; o < NUM_OCT; o++) begin
      scx = 40'((px2_q[o] + 52'sd32768) >>> 16);
      scy = 40'((py2_q[o] + 52'sd32768) >>> 16);
      ix3_d[o] = 32'(scx >>> FRAC_BITS);
      iy3_d[o] = 32'(scy >>> FRAC_BITS);
      fx3_d[o] = 16'((64'(scx[FRAC_BITS-1:0]) << 16) >> FRAC_BITS);
      fy3_d[o] = 16'((64'(scy[FRAC_BITS-1:0]) << 16) >> FRAC_BITS);

      kx = 18'd196608 - {1'b0, fx4_q[o], 1'b0};
      ky = 18'd196608 - {1'b0, fy4_q[o], 1'b0};
      wx5_d[o] = 16'((50'(tx4_q[o]) * 50'(kx)) >> 32);
      wy5_d[o] = 16'((50'(ty4_q[o]) * 50'(ky)) >> 32);

      acc = '0;
      for (int c = 0; c < NUM_CRN; c++) begin
        hs = ha4_q[o] + hb4_q[o] + hs4_q[o]
           + (c[0] ? HASH_MX : 32'd0) + (c[1] ? HASH_MY : 32'd0);
        h5_d[o][c] = hs ^ (hs >> 13);

        mv  = m6_q[o][c] ^ (m6_q[o][c] >> 16);
        crn = mv[31:16];
        wxt = c[0] ? {1'b0, wx6_q[o]} : 17'd65536 - {1'b0, wx6_q[o]};
        p7_d[o][c] = 33'(crn) * 33'(wxt);

        wyt = c[1] ? {1'b0, wy7_q[o]} : 17'd65536 - {1'b0, wy7_q[o]};
        q8_d[o][c] = 50'(p7_q[o][c]) * 50'(wyt);

        acc = acc + 51'(q8_q[o][c]);
      end
      oct9_d[o] = 32'(acc >> 16);
    end
  end

  always_comb begin
    logic [49:0] sum;
    sum = 50'(r10_q[0]) + 50'(r10_q[1]) + 50'(r10_q[2]);
    noise_d = fbm_q[NUM_STG-2] ? 16'(sum >> 32) : hi10_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx1_q <= coord_x_i;
      cy1_q <= coord_y_i;
      sd1_q <= seed_i;
      for (int o = 0; o < NUM_OCT; o++) begin
        px2_q[o] <= cx1_q * $signed({1'b0, OCT_SCALE[o]});
        py2_q[o] <= cy1_q * $signed({1'b0, OCT_SCALE[o]});
        sd2_q[o] <= sd1_q + OCT_SEED[o];

        ix3_q[o] <= ix3_d[o];
        iy3_q[o] <= iy3_d[o];
        fx3_q[o] <= fx3_d[o];
        fy3_q[o] <= fy3_d[o];
        sd3_q[o] <= sd2_q[o];

        ha4_q[o] <= ix3_q[o] * HASH_MX;
        hb4_q[o] <= iy3_q[o] * HASH_MY;
        hs4_q[o] <= sd3_q[o] * HASH_MS;
        tx4_q[o] <= 32'(fx3_q[o]) * 32'(fx3_q[o]);
        ty4_q[o] <= 32'(fy3_q[o]) * 32'(fy3_q[o]);
        fx4_q[o] <= fx3_q[o];
        fy4_q[o] <= fy3_q[o];

        wx5_q[o] <= wx5_d[o];
        wy5_q[o] <= wy5_d[o];
        wx6_q[o] <= wx5_q[o];
        wy6_q[o] <= wy5_q[o];
        wy7_q[o] <= wy6_q[o];
        for (int c = 0; c < NUM_CRN; c++) begin
          h5_q[o][c] <= h5_d[o][c];
          m6_q[o][c] <= h5_q[o][c] * HASH_MF;
          p7_q[o][c] <= p7_d[o][c];
          q8_q[o][c] <= q8_d[o][c];
        end

        oct9_q[o] <= oct9_d[o];
        r10_q[o]  <= 48'(oct9_q[o]) * 48'(OCT_WGT[o]);
      end
      hi10_q  <= oct9_q[0][31:16];
      noise_q <= noise_d;
    end
  end

endmodule

// File: tb/tb_value_noise_fbm_generator.sv
// Testbench for value_noise_fbm_generator: directed and random coordinate/seed words,
// with an in-bench noise predictor and an in-order scoreboard of expected values.
// Depends on vnf_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_value_noise_fbm_generator;
  import vnf_pkg::*;

  class noise_scoreboard;
    bit [15:0] expected_q[$];

    function automatic longint scale_c(longint c, longint k);
      return (c * k + 64'sd32768) >>> 16;
    endfunction

    function automatic bit [63:0] corner(bit [31:0] ix, bit [31:0] iy, bit [31:0] s);
      bit [31:0] h;
      h = ix * HASH_MX + iy * HASH_MY + s * HASH_MS;
      h = h ^ (h >> 13);
      h = h * HASH_MF;
      h = h ^ (h >> 16);
      return {48'd0, h[31:16]};
    endfunction

    function automatic bit [63:0] smooth(bit [63:0] t);
      return (t * t * (64'd196608 - 2 * t)) >> 32;
    endfunction

    function automatic bit [63:0] octave(longint x, longint y, bit [31:0] s);
      longint    xi, yi;
      bit [31:0] ix, iy;
      bit [63:0] wx, wy, a, b, c, d, one;
      one = 64'd65536;
      xi = x >>> 16;
      yi = y >>> 16;
      ix = xi[31:0];
      iy = yi[31:0];
      wx = smooth({48'd0, x[15:0]});
      wy = smooth({48'd0, y[15:0]});
      a = corner(ix, iy, s);
      b = corner(ix + 1, iy, s);
      c = corner(ix, iy + 1, s);
      d = corner(ix + 1, iy + 1, s);
      return (a * (one - wx) * (one - wy) + b * wx * (one - wy)
            + c * (one - wx) * wy + d * wx * wy) >> 16;
    endfunction

    function automatic void note_word(bit [31:0] cx, bit [31:0] cy, bit [31:0] s, bit fbm);
      longint    x, y;
      bit [63:0] o0, o1, o2, r;
      x = longint'($signed(cx));
      y = longint'($signed(cy));
      o0 = octave(scale_c(x, longint'(OCT_SCALE[0])), scale_c(y, longint'(OCT_SCALE[0])),
                  s + OCT_SEED[0]);
      if (fbm) begin
        o1 = octave(scale_c(x, longint'(OCT_SCALE[1])), scale_c(y, longint'(OCT_SCALE[1])),
                    s + OCT_SEED[1]);
        o2 = octave(scale_c(x, longint'(OCT_SCALE[2])), scale_c(y, longint'(OCT_SCALE[2])),
                    s + OCT_SEED[2]);
        r = (o0 * OCT_WGT[0] + o1 * OCT_WGT[1] + o2 * OCT_WGT[2]) >> 32;
      end else begin
        r = o0 >> 16;
      end
      expected_q = {expected_q, r[15:0]};
    endfunction

    // 0: match, 1: wrong value, 2: nothing pending
    function automatic int check_word(bit [15:0] got, output bit [15:0] want);
      want = '0;
      if (expected_q.size() == 0) return 2;
      want = expected_q.pop_front();
      return (got == want) ? 0 : 1;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] seed_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        noise_value_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  value_noise_fbm_generator dut (.*);

  noise_scoreboard sb = new();
  int  errors = 0;
  int  cycles = 0;
  bit  fbm_cfg = 1'b1;
  bit  in_taken = 1'b0;
  int  send_idle = 0;
  int  recv_idle = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report(string what, bit [15:0] got, bit [15:0] want);
    errors++;
    $display("mismatch: %s got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk_i) begin
    bit [15:0] want;
    int        rc;
    cycles++;
    if (cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) sb.note_word(coord_x_i, coord_y_i, seed_i, fbm_cfg);
    if (rst_ni && out_valid_o && out_ready_i) begin
      rc = sb.check_word(noise_value_o, want);
      if (rc == 1) report("noise_value", noise_value_o, want);
      else if (rc == 2) report("unexpected word", noise_value_o, want);
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle);

  task automatic send_word(bit [31:0] cx, bit [31:0] cy, bit [31:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= cx;
    coord_y_i  <= cy;
    seed_i     <= s;
    @(negedge clk_i);
    while (!in_taken) @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apb_write(bit [2:0] addr, bit [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_FBM_ADDR) fbm_cfg = data[0];
  endtask

  function automatic bit [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
      2: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
      default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  task automatic directed();
    send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF5);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFE9);
    send_word(32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFF4);
    send_word(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);
    send_word(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFEA);
    send_word(32'h7FFF_0000, 32'h8000_FFFF, 32'h1234_5678);
    send_word(32'hFFFF_0001, 32'h0000_0001, 32'hA5A5_A5A5);
    send_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h5A5A_5A5A);
    drain();
  endtask

  initial begin
    int n;
    send_idle = 28;
    recv_idle = 82;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed();
    apb_write(REG_FBM_ADDR, 32'hFFFF_FFFE);
    directed();
    for (int p = 0; p < 6; p++) begin
      send_idle = (p < 2) ? 28 : (p < 4) ? 82 : 0;
      recv_idle = (p < 2) ? 82 : (p < 4) ? 28 : 0;
      apb_write(REG_FBM_ADDR, (p == 0 || p == 3 || p == 4) ? 32'h0 : 32'h1);
      for (n = 0; n < 225; n++) send_word(rand_coord(), rand_coord(), $urandom());
      drain();
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/vnf_pkg.sv
rtl/value_noise_fbm_generator.sv
tb/tb_value_noise_fbm_generator.sv
